// ===== src/rhht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhht_pkg: shared types and constants for the Robin Hood hash table core
// Operation and status codes, hash multiplier, request control struct.
// ----------------------------------------------------------------------------
package rhht_pkg;

    localparam logic [31:0] FIB_MUL    = 32'h9E37_79B9;
    localparam int          LIMIT_W    = 11;
    localparam logic [10:0] FILL_RESET = 11'd768;

    typedef enum logic [1:0] {
        F_GET   = 2'd0,
        F_SET   = 2'd1,
        F_UNSET = 2'd2,
        F_CLEAR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_HIT  = 3'd0,
        ST_MISS = 3'd1,
        ST_NEW  = 3'd2,
        ST_UPD  = 3'd3,
        ST_FULL = 3'd4,
        ST_GONE = 3'd5
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [31:0] key;
    } t_req_ctl;

endpackage
`default_nettype wire

// ===== src/rhht_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhht_front: request intake
// Accepts operations, computes the Fibonacci home slot and queues requests.
// ----------------------------------------------------------------------------
module rhht_front #(
    parameter int AW      = 10,
    parameter int VALUE_W = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire rhht_pkg::t_req_ctl i_in_ctl,
    input  wire [VALUE_W-1:0]      i_in_value,
    input  wire                    i_busy,
    output logic                   o_req_valid,
    input  wire                    i_req_pop,
    output rhht_pkg::t_req_ctl     o_req_ctl,
    output logic [VALUE_W-1:0]     o_req_value,
    output logic [AW-1:0]          o_req_home
);
    import rhht_pkg::*;

    localparam int QD = 2;
    localparam int QA = $clog2(QD);

    logic               r_s1_valid;
    t_req_ctl           r_s1_ctl;
    logic [VALUE_W-1:0] r_s1_value;
    logic [31:0]        r_s1_prod;

    t_req_ctl           r_q_ctl   [QD];
    logic [VALUE_W-1:0] r_q_value [QD];
    logic [AW-1:0]      r_q_home  [QD];
    logic [QA:0]        r_wp;
    logic [QA:0]        r_rp;

    logic q_full;
    logic q_empty;
    logic push;
    logic take;

    assign q_empty    = (r_wp == r_rp);
    assign q_full     = (r_wp[QA-1:0] == r_rp[QA-1:0]) && (r_wp[QA] != r_rp[QA]);
    assign push       = r_s1_valid && !q_full;
    assign o_in_ready = !i_busy && (!r_s1_valid || !q_full);
    assign take       = i_in_valid && o_in_ready;

    // hash stage: register the low product word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take) begin
            r_s1_valid <= 1'b1;
        end else if (push) begin
            r_s1_valid <= 1'b0;
        end
        if (take) begin
            r_s1_ctl   <= i_in_ctl;
            r_s1_value <= i_in_value;
            r_s1_prod  <= i_in_ctl.key * FIB_MUL;
        end
    end

    // request queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_req_pop && !q_empty) r_rp <= r_rp + 1'b1;
        end
        if (push) begin
            r_q_ctl[r_wp[QA-1:0]]   <= r_s1_ctl;
            r_q_value[r_wp[QA-1:0]] <= r_s1_value;
            r_q_home[r_wp[QA-1:0]]  <= r_s1_prod[31 -: AW];
        end
    end

    assign o_req_valid = !q_empty;
    assign o_req_ctl   = r_q_ctl[r_rp[QA-1:0]];
    assign o_req_value = r_q_value[r_rp[QA-1:0]];
    assign o_req_home  = r_q_home[r_rp[QA-1:0]];

endmodule
`default_nettype wire

// ===== src/rhht_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhht_back: probe engine
// Walks the slot memory for lookup, insertion with
// displacement, backward-shift removal and clearing sweeps.
// ----------------------------------------------------------------------------
module rhht_back #(
    parameter int SLOTS   = 1024,
    parameter int AW      = 10,
    parameter int VALUE_W = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_req_valid,
    output logic                    o_req_pop,
    input  wire rhht_pkg::t_req_ctl i_req_ctl,
    input  wire [VALUE_W-1:0]       i_req_value,
    input  wire [AW-1:0]            i_req_home,
    input  wire [10:0]              i_fill_limit,
    output logic                    o_busy,
    output logic                    o_res_valid,
    input  wire                     i_res_ready,
    output rhht_pkg::t_status       o_res_status,
    output logic [31:0]             o_res_value,
    output logic [10:0]             o_res_count
);
    import rhht_pkg::*;

    localparam int CW = AW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [AW:0]   SLOTS_C = (AW+1)'(SLOTS);
    localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FRD, S_FCHK, S_IRD, S_ICHK, S_RRD, S_RCHK, S_CLR, S_DONE
    } t_state;

    // slot memory
    logic               m_valid [SLOTS];
    logic [AW-1:0]      m_dist  [SLOTS];
    logic [31:0]        m_key   [SLOTS];
    logic [VALUE_W-1:0] m_val   [SLOTS];

    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_dist;
    logic [31:0]        r_rd_key;
    logic [VALUE_W-1:0] r_rd_val;

    t_state             r_state;
    t_func              r_func;
    logic [31:0]        r_key;
    logic [VALUE_W-1:0] r_val;
    logic [AW-1:0]      r_home;
    logic [AW-1:0]      r_slot;
    logic [AW-1:0]      r_hole;
    logic [AW:0]        r_d;
    logic [CW-1:0]      r_count;
    t_status            r_status;
    logic [VALUE_W-1:0] r_vout;
    logic               r_res_valid;
    t_status            r_res_status;
    logic [31:0]        r_res_value;
    logic [10:0]        r_res_count;

    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic               w_valid;
    logic [AW-1:0]      w_dist;
    logic [31:0]        w_key;
    logic [VALUE_W-1:0] w_val;

    logic          dist_lt_d;
    logic          key_eq;
    logic          bound_hit;
    logic          is_full;
    logic [LW-1:0] lim;
    logic [LW-1:0] fill_ext;
    logic [LW-1:0] cnt_ext;
    logic [63:0]   vout_wide;
    logic [31:0]   cnt_wide;
    logic          res_free;

    assign dist_lt_d = ({1'b0, r_rd_dist} < r_d);
    assign key_eq    = (r_rd_key == r_key);
    assign bound_hit = ((r_d + 1'b1) == SLOTS_C);
    assign fill_ext  = LW'(i_fill_limit);
    assign cnt_ext   = LW'(r_count);
    assign lim       = (fill_ext > SLOTS_L) ? SLOTS_L : fill_ext;
    assign is_full   = (cnt_ext >= lim);
    assign vout_wide = 64'(r_vout);
    assign cnt_wide  = 32'(r_count);
    assign res_free  = !r_res_valid || i_res_ready;

    // memory write selection
    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_slot;
        w_valid = 1'b1;
        w_dist  = r_d[AW-1:0];
        w_key   = r_key;
        w_val   = r_val;
        unique case (r_state)
            S_INIT, S_CLR: begin
                w_en    = 1'b1;
                w_valid = 1'b0;
            end
            S_FCHK: begin
                // overwrite value of a matching key on set
                w_en   = r_rd_valid && !dist_lt_d && key_eq && (r_func == F_SET);
                w_dist = r_rd_dist;
            end
            S_ICHK: begin
                w_en = !r_rd_valid || (r_rd_dist < r_d[AW-1:0]);
            end
            S_RCHK: begin
                w_en   = 1'b1;
                w_addr = r_hole;
                if (r_d == SLOTS_C || !r_rd_valid || r_rd_dist == '0) begin
                    w_valid = 1'b0;
                end else begin
                    w_dist = r_rd_dist - 1'b1;
                    w_key  = r_rd_key;
                    w_val  = r_rd_val;
                end
            end
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_valid[w_addr] <= w_valid;
            m_dist[w_addr]  <= w_dist;
            m_key[w_addr]   <= w_key;
            m_val[w_addr]   <= w_val;
        end
        r_rd_valid <= m_valid[r_slot];
        r_rd_dist  <= m_dist[r_slot];
        r_rd_key   <= m_key[r_slot];
        r_rd_val   <= m_val[r_slot];
    end

    assign o_req_pop = (r_state == S_IDLE) && i_req_valid;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_slot      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready && r_state != S_DONE) r_res_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == AW'(SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_func <= i_req_ctl.func;
                        r_key  <= i_req_ctl.key;
                        r_val  <= i_req_value;
                        r_home <= i_req_home;
                        r_d    <= '0;
                        r_vout <= '0;
                        if (i_req_ctl.func == F_CLEAR) begin
                            r_slot  <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_slot  <= i_req_home;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (!r_rd_valid || dist_lt_d || (!key_eq && bound_hit)) begin
                        // key absent
                        if (r_func == F_SET && !is_full) begin
                            r_slot  <= r_home;
                            r_d     <= '0;
                            r_state <= S_IRD;
                        end else begin
                            r_status <= (r_func == F_SET) ? ST_FULL : ST_MISS;
                            r_state  <= S_DONE;
                        end
                    end else if (key_eq) begin
                        unique case (r_func)
                            F_GET: begin
                                r_status <= ST_HIT;
                                r_vout   <= r_rd_val;
                                r_state  <= S_DONE;
                            end
                            F_SET: begin
                                r_status <= ST_UPD;
                                r_vout   <= r_rd_val;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_count <= r_count - 1'b1;
                                r_hole  <= r_slot;
                                r_slot  <= r_slot + 1'b1;
                                r_d     <= '0;
                                r_state <= S_RRD;
                            end
                        endcase
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_d     <= r_d + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_IRD: r_state <= S_ICHK;
                S_ICHK: begin
                    if (!r_rd_valid) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_NEW;
                        r_state  <= S_DONE;
                    end else begin
                        // carry the displaced entry onward
                        if (r_rd_dist < r_d[AW-1:0]) begin
                            r_key <= r_rd_key;
                            r_val <= r_rd_val;
                            r_d   <= {1'b0, r_rd_dist} + 1'b1;
                        end else begin
                            r_d <= r_d + 1'b1;
                        end
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_IRD;
                    end
                end
                S_RRD: r_state <= S_RCHK;
                S_RCHK: begin
                    if (r_d == SLOTS_C || !r_rd_valid || r_rd_dist == '0) begin
                        r_status <= ST_GONE;
                        r_state  <= S_DONE;
                    end else begin
                        r_hole  <= r_slot;
                        r_slot  <= r_slot + 1'b1;
                        r_d     <= r_d + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_CLR: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == AW'(SLOTS - 1)) begin
                        r_count  <= '0;
                        r_status <= ST_GONE;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_free) begin
                        r_res_valid  <= 1'b1;
                        r_res_status <= r_status;
                        r_res_value  <= vout_wide[31:0];
                        r_res_count  <= cnt_wide[10:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state == S_INIT);
    assign o_res_valid  = r_res_valid;
    assign o_res_status = r_res_status;
    assign o_res_value  = r_res_value;
    assign o_res_count  = r_res_count;

endmodule
`default_nettype wire

// ===== src/robin_hood_hash_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core: fixed-capacity Robin Hood hash map
// Lookup, displacement and shift walks probe slot by slot; clear sweeps all
//   slots; one operation in the probe engine at a time, others wait in the front queue.
// Reset: synchronous, active low; afterwards a sweep empties the slot memory
//   and no item is accepted until it ends.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_core #(
    parameter int SLOTS   = 1024,
    parameter int VALUE_W = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // key[31:0], value_in[VALUE_W-1:0]
    input  wire [((32+VALUE_W+7)/8)*8-1:0] i_s_tdata,
    // func[1:0]
    input  wire [1:0]            i_s_tuser,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // value_out[31:0], entry_count[42:32]
    output logic [47:0]          o_m_tdata,
    // status[2:0]
    output logic [2:0]           o_m_tuser,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [10:0]           i_cfg_data
);
    import rhht_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [10:0]        r_fill_limit;
    t_req_ctl           in_ctl;
    logic               req_valid;
    logic               req_pop;
    t_req_ctl           req_ctl;
    logic [VALUE_W-1:0] req_value;
    logic [AW-1:0]      req_home;
    logic               busy;
    t_status            res_status;
    logic [31:0]        res_value;
    logic [10:0]        res_count;

    // hold the fill limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_RESET;
        end else if (i_cfg_valid) begin
            r_fill_limit <= i_cfg_data;
        end
    end

    assign in_ctl.func = t_func'(i_s_tuser);
    assign in_ctl.key  = i_s_tdata[31:0];

    rhht_front #(.AW(AW), .VALUE_W(VALUE_W)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_ctl    (in_ctl),
        .i_in_value  (i_s_tdata[32 +: VALUE_W]),
        .i_busy      (busy),
        .o_req_valid (req_valid),
        .i_req_pop   (req_pop),
        .o_req_ctl   (req_ctl),
        .o_req_value (req_value),
        .o_req_home  (req_home)
    );

    rhht_back #(.SLOTS(SLOTS), .AW(AW), .VALUE_W(VALUE_W)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .o_req_pop    (req_pop),
        .i_req_ctl    (req_ctl),
        .i_req_value  (req_value),
        .i_req_home   (req_home),
        .i_fill_limit (r_fill_limit),
        .o_busy       (busy),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_res_status (res_status),
        .o_res_value  (res_value),
        .o_res_count  (res_count)
    );

    assign o_m_tdata = {5'd0, res_count, res_value};
    assign o_m_tuser = res_status;

endmodule
`default_nettype wire

// ===== src/rhht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhht_checker: port-level checks for the hash table core
// Watches the result stream for consistency over time.
// ----------------------------------------------------------------------------
module rhht_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [47:0] o_m_tdata,
    input wire [2:0]  o_m_tuser,
    input wire        o_s_tready
);
    import rhht_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // a hit or insert leaves at least one entry
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_HIT || o_m_tuser == ST_NEW || o_m_tuser == ST_UPD)
        |-> o_m_tdata[42:32] != 11'd0)
        else $error("entry count zero after hit or insert");

    // only hit and update carry a value
    a_zero_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !(o_m_tuser == ST_HIT || o_m_tuser == ST_UPD)
        |-> o_m_tdata[31:0] == 32'd0)
        else $error("value on result without a hit");

    // nothing is produced or accepted right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("activity right after reset");

endmodule

bind robin_hood_hash_table_core rhht_checker u_rhht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_s_tready (o_s_tready)
);
`default_nettype wire

// ===== verif/tb_robin_hood_hash_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_table_core: self-checking bench for the hash table core
// Streams get/set/unset/clear requests with random stalls on both sides,
// mirrors the map in a local Robin Hood table and checks every response.
// ----------------------------------------------------------------------------
module tb_robin_hood_hash_table_core;
    import rhht_pkg::*;

    localparam int SLOTS     = 1024;
    localparam int VALUE_W   = 32;
    localparam int HASH_BITS = $clog2(SLOTS);
    localparam int LIMIT     = 1_000_000;

    typedef struct packed {
        t_func       func;
        logic [31:0] key;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
        logic [10:0] count;
    } t_response;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [47:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [10:0]  i_cfg_data;

    robin_hood_hash_table_core #(.SLOTS(SLOTS), .VALUE_W(VALUE_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the slot memory
    bit          slot_used [SLOTS];
    logic [31:0] slot_key  [SLOTS];
    logic [31:0] slot_val  [SLOTS];
    int unsigned slot_dist [SLOTS];
    int unsigned map_count;
    logic [10:0] fill_limit;

    t_request    pending_q[$];
    t_response   response_q[$];
    int unsigned cycle_cnt;
    int unsigned mismatch_cnt;
    int unsigned status_seen [6];
    bit          quiet;
    bit          req_taken;
    logic [31:0] key_pool[$];

    // ---------------------------------------------------------------- predictor
    function automatic int unsigned home_of(logic [31:0] key);
        logic [31:0] h;
        h = key * FIB_MUL;
        return int'(h >> (32 - HASH_BITS));
    endfunction

    function automatic int locate(logic [31:0] key);
        int unsigned s;
        s = home_of(key);
        for (int unsigned d = 0; d < SLOTS; d++) begin
            if (!slot_used[s] || slot_dist[s] < d) return -1;
            if (slot_key[s] == key) return int'(s);
            s = (s + 1) % SLOTS;
        end
        return -1;
    endfunction

    function automatic void place_new(logic [31:0] key, logic [31:0] value);
        int unsigned s, cd, td;
        logic [31:0] ck, cv, tk, tv;
        s = home_of(key);
        ck = key;
        cv = value;
        cd = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[s]) begin
                slot_used[s] = 1;
                slot_key[s]  = ck;
                slot_val[s]  = cv;
                slot_dist[s] = cd;
                map_count++;
                return;
            end
            // swap with a richer resident
            if (slot_dist[s] < cd) begin
                tk = slot_key[s];
                tv = slot_val[s];
                td = slot_dist[s];
                slot_key[s]  = ck;
                slot_val[s]  = cv;
                slot_dist[s] = cd;
                ck = tk;
                cv = tv;
                cd = td;
            end
            s = (s + 1) % SLOTS;
            cd++;
        end
    endfunction

    function automatic void shift_out(int unsigned s);
        int unsigned nx;
        map_count--;
        for (int n = 0; n < SLOTS; n++) begin
            nx = (s + 1) % SLOTS;
            if (!slot_used[nx] || slot_dist[nx] == 0) break;
            slot_key[s]  = slot_key[nx];
            slot_val[s]  = slot_val[nx];
            slot_dist[s] = slot_dist[nx] - 1;
            s = nx;
        end
        slot_used[s] = 0;
    endfunction

    function automatic t_response apply_request(t_request r);
        t_response   o;
        int          f;
        int unsigned lim;
        o.status = ST_MISS;
        o.value  = '0;
        if (r.func == F_CLEAR) begin
            foreach (slot_used[i]) slot_used[i] = 0;
            map_count = 0;
            o.status  = ST_GONE;
        end else begin
            f = locate(r.key);
            if (r.func == F_GET) begin
                if (f >= 0) begin
                    o.status = ST_HIT;
                    o.value  = slot_val[f];
                end
            end else if (r.func == F_SET) begin
                if (f >= 0) begin
                    o.status    = ST_UPD;
                    o.value     = slot_val[f];
                    slot_val[f] = r.value;
                end else begin
                    lim = (fill_limit > SLOTS) ? SLOTS : fill_limit;
                    if (map_count >= lim) begin
                        o.status = ST_FULL;
                    end else begin
                        place_new(r.key, r.value);
                        o.status = ST_NEW;
                    end
                end
            end else if (f >= 0) begin
                shift_out(f);
                o.status = ST_GONE;
            end
        end
        o.count = map_count[10:0];
        return o;
    endfunction

    // ---------------------------------------------------------------- clock, timeout
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("robin_hood_hash_table_core verification failed");
            $finish;
        end
    end

    function automatic bit stall();
        return !quiet && ($urandom_range(0, 99) < 25);
    endfunction

    // ---------------------------------------------------------------- request driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            response_q.push_back(apply_request({t_func'(i_s_tuser), i_s_tdata[31:0],
                                                i_s_tdata[63:32]}));
            req_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || !i_s_tvalid || req_taken) begin
            req_taken = 0;
            if (pending_q.size() > 0 && !stall()) begin
                i_s_tvalid <= 1;
                i_s_tuser  <= pending_q[0].func;
                i_s_tdata  <= {pending_q[0].value, pending_q[0].key};
                void'(pending_q.pop_front());
            end else begin
                i_s_tvalid <= 0;
            end
        end
        i_m_tready <= !stall();
    end

    // ---------------------------------------------------------------- response monitor
    always @(posedge i_clk) begin
        t_response exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (o_m_tuser < 6) status_seen[o_m_tuser]++;
            if (response_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected response status=%0d value=%h count=%0d",
                             o_m_tuser, o_m_tdata[31:0], o_m_tdata[42:32]);
            end else begin
                exp_r = response_q.pop_front();
                if (o_m_tuser !== exp_r.status || o_m_tdata[31:0] !== exp_r.value ||
                    o_m_tdata[42:32] !== exp_r.count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp status=%0d value=%h count=%0d, got %0d %h %0d",
                                 exp_r.status, exp_r.value, exp_r.count,
                                 o_m_tuser, o_m_tdata[31:0], o_m_tdata[42:32]);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic push(t_func f, logic [31:0] k, logic [31:0] v);
        pending_q.push_back({f, k, v});
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_s_tvalid || response_q.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [10:0] lim);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        fill_limit = lim;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_ops(int n, int clear_pct);
        int unsigned pick;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                             : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < clear_pct)    push(F_CLEAR, $urandom, $urandom);
            else if (pick < 50)      push(F_SET, k, $urandom);
            else if (pick < 75)      push(F_GET, k, $urandom);
            else                     push(F_UNSET, k, $urandom);
        end
    endtask

    initial begin
        logic [31:0] chain_a[$];
        logic [31:0] chain_b[$];
        int unsigned base;

        i_rst_n     = 0;
        i_s_tvalid  = 0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 0;
        i_cfg_valid = 0;
        i_cfg_data  = '0;
        cycle_cnt   = 0;
        mismatch_cnt = 0;
        quiet       = 0;
        req_taken   = 0;
        map_count   = 0;
        fill_limit  = FILL_RESET;
        foreach (slot_used[i]) slot_used[i] = 0;

        // keys sharing a home slot, and the next slot, to build probe chains
        base = home_of(32'h1234_5678);
        for (logic [31:0] k = 1; chain_a.size() < 4 || chain_b.size() < 3; k++) begin
            if (home_of(k) == base && chain_a.size() < 4) chain_a.push_back(k);
            if (home_of(k) == (base + 1) % SLOTS && chain_b.size() < 3) chain_b.push_back(k);
        end
        for (int i = 0; i < 56; i++) key_pool.push_back($urandom);
        foreach (chain_a[i]) key_pool.push_back(chain_a[i]);
        foreach (chain_b[i]) key_pool.push_back(chain_b[i]);
        key_pool.push_back(32'h0);
        key_pool.push_back(32'hFFFF_FFFF);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, collisions, displacement and backward shift
        push(F_GET,   32'h0,         32'h0);
        push(F_SET,   32'h0,         32'h0);
        push(F_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(F_GET,   32'h0,         32'h0);
        push(F_SET,   32'h0,         32'hA5A5_5A5A);
        push(F_UNSET, 32'h1357_9BDF, 32'h0);
        push(F_SET,   chain_b[0],    32'h11);
        push(F_SET,   chain_a[0],    32'h21);
        push(F_SET,   chain_a[1],    32'h22);
        push(F_SET,   chain_a[2],    32'h23);
        push(F_SET,   chain_b[1],    32'h12);
        push(F_GET,   chain_b[1],    32'h0);
        push(F_UNSET, chain_a[0],    32'h0);
        push(F_GET,   chain_a[2],    32'h0);
        push(F_GET,   chain_a[3],    32'h0);
        push(F_UNSET, 32'hFFFF_FFFF, 32'h0);
        push(F_CLEAR, 32'h0,         32'h0);
        push(F_GET,   chain_a[1],    32'h0);
        drain();

        // small limit: refuse new keys, still update existing ones
        write_limit(11'd4);
        for (int i = 0; i < 6; i++) push(F_SET, key_pool[i], $urandom);
        push(F_SET, key_pool[0], 32'hDEAD_BEEF);
        drain();
        write_limit(11'd0);
        push(F_SET, 32'h7777_7777, 32'h1);
        push(F_SET, key_pool[1], 32'h2);
        push(F_CLEAR, 32'h0, 32'h0);
        drain();

        // main random run with the largest limit, part of it without stalls
        write_limit(11'd2047);
        random_ops(150, 1);
        drain();
        quiet = 1;
        random_ops(150, 1);
        drain();
        quiet = 0;
        write_limit(11'd1024);
        random_ops(100, 1);
        drain();
        write_limit(11'd1);
        random_ops(40, 2);
        drain();
        write_limit(11'd40);
        random_ops(100, 1);
        drain();

        $display("covered %0d hits, %0d misses, %0d inserts, %0d updates, %0d refusals,",
                 status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_NEW],
                 status_seen[ST_UPD], status_seen[ST_FULL]);
        $display("%0d removals/clears over limits 768, 4, 0, 2047, 1024, 1 and 40",
                 status_seen[ST_GONE]);
        if (mismatch_cnt == 0) begin
            $display("robin_hood_hash_table_core verification clean");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("robin_hood_hash_table_core verification failed");
        end
        $finish;
    end

endmodule
